/* src/brr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types, widths and helpers for the biquadratic real root solver.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int DW       = 32;              // Q16.16 word
  localparam int SQ_IN    = 66;              // square root radicand
  localparam int SQ_OUT   = SQ_IN / 2;       // root bits
  localparam int SQ_LAT   = SQ_OUT;          // one root bit per stage
  localparam int SQ_REM_W = SQ_OUT + 3;
  localparam int NUM_W    = 49;              // |(-b +/- s)| * 2^15
  localparam int DEN_W    = 32;              // |a|
  localparam int DV_LAT   = NUM_W;           // one quotient bit per stage
  localparam int FRAC_Y   = 15;

  typedef struct packed {
    logic signed [DW-1:0] coef_quartic;
    logic signed [DW-1:0] coef_square;
    logic signed [DW-1:0] coef_const;
  } coef_t;

  typedef struct packed {
    logic                 status;
    logic [2:0]           root_count;
    logic signed [DW-1:0] root_first;
    logic signed [DW-1:0] root_second;
    logic signed [DW-1:0] root_third;
    logic signed [DW-1:0] root_fourth;
    logic                 overflow;
  } result_t;

  function automatic logic [DW-1:0] mag32(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // floor correction and saturation of a quotient magnitude; {ovf, y}
  function automatic logic [DW:0] quot_fix(input logic [NUM_W-1:0] qm,
                                           input logic rnz, input logic neg);
    logic [NUM_W:0] m;
    logic           ovf;
    logic [DW-1:0]  y;
    m = {1'b0, qm} + (NUM_W+1)'(neg & rnz);
    if (neg) begin
      ovf = m > (NUM_W+1)'(64'h8000_0000);
      y   = ovf ? 32'h8000_0000 : (~m[DW-1:0] + DW'(1));
    end else begin
      ovf = m > (NUM_W+1)'(64'h7FFF_FFFF);
      y   = ovf ? 32'h7FFF_FFFF : m[DW-1:0];
    end
    return {ovf, y};
  endfunction

endpackage

/* src/brr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_if
// Valid/ready channels for coefficient requests and root results.
// ----------------------------------------------------------------------------
interface brr_in_if;
  logic          valid;
  logic          ready;
  brr_pkg::coef_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface brr_out_if;
  logic             valid;
  logic             ready;
  brr_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/brr_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module brr_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [brr_pkg::SQ_IN-1:0]   radicand,
  output logic                        out_valid,
  output logic [brr_pkg::SQ_OUT-1:0]  root
);
  import brr_pkg::*;

  logic                v    [SQ_LAT];
  logic [SQ_IN-1:0]    rad  [SQ_LAT];
  logic [SQ_REM_W-1:0] rem  [SQ_LAT];
  logic [SQ_OUT-1:0]   rt   [SQ_LAT];
  logic [SQ_IN-1:0]    rad_c[SQ_LAT];
  logic [SQ_REM_W-1:0] rem_c[SQ_LAT];
  logic [SQ_OUT-1:0]   rt_c [SQ_LAT];
  logic [SQ_REM_W-1:0] cur  [SQ_LAT];
  logic [SQ_REM_W-1:0] trial[SQ_LAT];
  logic                take [SQ_LAT];

  always_comb begin
    rad_c[0] = radicand;
    rem_c[0] = '0;
    rt_c[0]  = '0;
    for (int s = 1; s < SQ_LAT; s++) begin
      rad_c[s] = rad[s-1];
      rem_c[s] = rem[s-1];
      rt_c[s]  = rt[s-1];
    end
    for (int s = 0; s < SQ_LAT; s++) begin
      cur[s]   = {rem_c[s][SQ_REM_W-3:0], rad_c[s][SQ_IN-1 -: 2]};
      trial[s] = {{(SQ_REM_W-SQ_OUT-2){1'b0}}, rt_c[s], 2'b01};
      take[s]  = cur[s] >= trial[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    for (int s = 1; s < SQ_LAT; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end
    if (en) begin
      for (int s = 0; s < SQ_LAT; s++) begin
        rad[s] <= {rad_c[s][SQ_IN-3:0], 2'b00};
        rem[s] <= take[s] ? (cur[s] - trial[s]) : cur[s];
        rt[s]  <= {rt_c[s][SQ_OUT-2:0], take[s]};
      end
    end
  end

  assign out_valid = v[SQ_LAT-1];
  assign root      = rt[SQ_LAT-1];

endmodule

/* src/brr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module brr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [brr_pkg::NUM_W-1:0]  num,
  input  logic [brr_pkg::DEN_W-1:0]  den,
  output logic                       out_valid,
  output logic [brr_pkg::NUM_W-1:0]  quot,
  output logic                       rem_nz
);
  import brr_pkg::*;

  logic             v   [DV_LAT];
  logic [NUM_W-1:0] nq  [DV_LAT];
  logic [DEN_W-1:0] rm  [DV_LAT];
  logic [DEN_W-1:0] dn  [DV_LAT];
  logic [NUM_W-1:0] nq_c[DV_LAT];
  logic [DEN_W-1:0] rm_c[DV_LAT];
  logic [DEN_W-1:0] dn_c[DV_LAT];
  logic [DEN_W:0]   cur [DV_LAT];
  logic             take[DV_LAT];

  always_comb begin
    nq_c[0] = num;
    rm_c[0] = '0;
    dn_c[0] = den;
    for (int s = 1; s < DV_LAT; s++) begin
      nq_c[s] = nq[s-1];
      rm_c[s] = rm[s-1];
      dn_c[s] = dn[s-1];
    end
    for (int s = 0; s < DV_LAT; s++) begin
      cur[s]  = {rm_c[s], nq_c[s][NUM_W-1]};
      take[s] = cur[s] >= {1'b0, dn_c[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    for (int s = 1; s < DV_LAT; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end
    if (en) begin
      for (int s = 0; s < DV_LAT; s++) begin
        nq[s] <= {nq_c[s][NUM_W-2:0], take[s]};
        rm[s] <= take[s] ? DEN_W'(cur[s] - {1'b0, dn_c[s]}) : cur[s][DEN_W-1:0];
        dn[s] <= dn_c[s];
      end
    end
  end

  assign out_valid = v[DV_LAT-1];
  assign quot      = nq[DV_LAT-1];
  assign rem_nz    = |rm[DV_LAT-1];

endmodule

/* src/biquadratic_real_roots.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquadratic_real_roots
// Real roots of a*x^4 + b*x^2 + c = 0 in signed Q16.16.
// ----------------------------------------------------------------------------
// One coefficient request enters every cycle while the output is not stalled. It
// passes through the products register, the discriminant register, the
// discriminant square root, the numerator register, the two dividers, the
// saturation register, the two root square roots and one output register. The
// whole pipeline advances together whenever the output register is free or is
// being taken; a stalled result holds every stage in place.
// ----------------------------------------------------------------------------
module biquadratic_real_roots (
  input  logic      clk,
  input  logic      rst,
  brr_in_if.sink    coefs,
  brr_out_if.source roots
);
  import brr_pkg::*;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic                 azero;
    logic                 dneg;
    logic                 dzero;
  } disc_side_t;

  typedef struct packed {
    logic azero;
    logic dneg;
    logic dzero;
    logic neg1;
    logic neg2;
  } div_side_t;

  typedef struct packed {
    logic                 azero;
    logic                 dneg;
    logic                 dzero;
    logic signed [DW-1:0] y1;
    logic signed [DW-1:0] y2;
    logic                 ovf1;
    logic                 ovf2;
  } root_side_t;

  logic en;

  // products
  logic                 v1;
  logic [2*DW-1:0]      pbb, pac;
  logic                 ac_opp;
  logic signed [DW-1:0] a1, b1;

  // discriminant
  logic                 v2;
  logic [SQ_IN-1:0]     disc;
  logic [SQ_IN:0]       qq, p4, dsum, ddif;
  disc_side_t           ds2;

  logic                 sq_valid;
  logic [SQ_OUT-1:0]    s_root;
  disc_side_t           ds_dly [SQ_LAT];

  // numerators
  logic                 v3;
  logic signed [SQ_OUT+1:0] nb, n1, n2;
  logic [NUM_W-1:0]     num1, num2;
  logic [DEN_W-1:0]     den;
  div_side_t            dv3;
  div_side_t            dv_dly [DV_LAT];

  logic                 dv1_valid, dv2_valid;
  logic [NUM_W-1:0]     q1, q2;
  logic                 rnz1, rnz2;
  logic [DW:0]          f1, f2;

  // quotients
  logic                 v4;
  root_side_t           rs4;
  root_side_t           rs_dly [SQ_LAT];
  logic                 r1_valid, r2_valid;
  logic [SQ_OUT-1:0]    r1, r2;

  // output
  logic                 ovalid;
  result_t              odata, onext;
  logic [DW-1:0]        slot [4];
  logic [2:0]           cnt;
  root_side_t           rs_end;

  assign en          = !ovalid || roots.ready;
  assign coefs.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= coefs.valid;
    end
    if (en) begin
      pbb    <= mag32(coefs.data.coef_square) * mag32(coefs.data.coef_square);
      pac    <= mag32(coefs.data.coef_quartic) * mag32(coefs.data.coef_const);
      ac_opp <= coefs.data.coef_quartic[DW-1] ^ coefs.data.coef_const[DW-1];
      a1     <= coefs.data.coef_quartic;
      b1     <= coefs.data.coef_square;
    end
  end

  always_comb begin
    qq   = {3'b000, pbb};
    p4   = {1'b0, pac, 2'b00};
    dsum = qq + p4;
    ddif = qq - p4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ds2.a     <= a1;
      ds2.b     <= b1;
      ds2.azero <= a1 == '0;
      priority if (pac != '0 && ac_opp) begin
        disc      <= dsum[SQ_IN-1:0];
        ds2.dneg  <= 1'b0;
        ds2.dzero <= 1'b0;
      end else if (p4 > qq) begin
        disc      <= '0;
        ds2.dneg  <= 1'b1;
        ds2.dzero <= 1'b0;
      end else begin
        disc      <= ddif[SQ_IN-1:0];
        ds2.dneg  <= 1'b0;
        ds2.dzero <= ddif == '0;
      end
    end
  end

  brr_sqrt u_sqrt_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .radicand  (disc),
    .out_valid (sq_valid),
    .root      (s_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ds_dly[0] <= ds2;
      for (int i = 1; i < SQ_LAT; i++) begin
        ds_dly[i] <= ds_dly[i-1];
      end
    end
  end

  always_comb begin
    nb = -(SQ_OUT+2)'(ds_dly[SQ_LAT-1].b);
    n1 = nb + (SQ_OUT+2)'({1'b0, s_root});
    n2 = nb - (SQ_OUT+2)'({1'b0, s_root});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= sq_valid;
    end
    if (en) begin
      num1      <= {1'b0, (n1[SQ_OUT+1] ? SQ_OUT'(-n1) : n1[SQ_OUT-1:0]), FRAC_Y'(0)};
      num2      <= {1'b0, (n2[SQ_OUT+1] ? SQ_OUT'(-n2) : n2[SQ_OUT-1:0]), FRAC_Y'(0)};
      den       <= mag32(ds_dly[SQ_LAT-1].a);
      dv3.azero <= ds_dly[SQ_LAT-1].azero;
      dv3.dneg  <= ds_dly[SQ_LAT-1].dneg;
      dv3.dzero <= ds_dly[SQ_LAT-1].dzero;
      dv3.neg1  <= n1[SQ_OUT+1] ^ ds_dly[SQ_LAT-1].a[DW-1];
      dv3.neg2  <= n2[SQ_OUT+1] ^ ds_dly[SQ_LAT-1].a[DW-1];
    end
  end

  brr_div u_div_y1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (num1),
    .den       (den),
    .out_valid (dv1_valid),
    .quot      (q1),
    .rem_nz    (rnz1)
  );

  brr_div u_div_y2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (num2),
    .den       (den),
    .out_valid (dv2_valid),
    .quot      (q2),
    .rem_nz    (rnz2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_dly[0] <= dv3;
      for (int i = 1; i < DV_LAT; i++) begin
        dv_dly[i] <= dv_dly[i-1];
      end
    end
  end

  always_comb begin
    f1 = quot_fix(q1, rnz1, dv_dly[DV_LAT-1].neg1);
    f2 = quot_fix(q2, rnz2, dv_dly[DV_LAT-1].neg2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= dv1_valid && dv2_valid;
    end
    if (en) begin
      rs4.azero <= dv_dly[DV_LAT-1].azero;
      rs4.dneg  <= dv_dly[DV_LAT-1].dneg;
      rs4.dzero <= dv_dly[DV_LAT-1].dzero;
      rs4.y1    <= f1[DW-1:0];
      rs4.y2    <= f2[DW-1:0];
      rs4.ovf1  <= f1[DW];
      rs4.ovf2  <= f2[DW];
    end
  end

  brr_sqrt u_sqrt_y1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .radicand  (rs4.y1[DW-1] ? '0 : {(SQ_IN-DW-16)'(0), rs4.y1, 16'h0000}),
    .out_valid (r1_valid),
    .root      (r1)
  );

  brr_sqrt u_sqrt_y2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .radicand  (rs4.y2[DW-1] ? '0 : {(SQ_IN-DW-16)'(0), rs4.y2, 16'h0000}),
    .out_valid (r2_valid),
    .root      (r2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rs_dly[0] <= rs4;
      for (int i = 1; i < SQ_LAT; i++) begin
        rs_dly[i] <= rs_dly[i-1];
      end
    end
  end

  always_comb begin
    rs_end = rs_dly[SQ_LAT-1];
    for (int k = 0; k < 4; k++) begin
      slot[k] = '0;
    end
    cnt = 3'd0;
    if (!rs_end.azero && !rs_end.dneg) begin
      if (!rs_end.y1[DW-1]) begin
        slot[cnt[1:0]] = r1[DW-1:0];
        cnt = cnt + 3'd1;
        if (rs_end.y1 != '0) begin
          slot[cnt[1:0]] = ~r1[DW-1:0] + DW'(1);
          cnt = cnt + 3'd1;
        end
      end
      if (!rs_end.dzero && !rs_end.y2[DW-1]) begin
        slot[cnt[1:0]] = r2[DW-1:0];
        cnt = cnt + 3'd1;
        if (rs_end.y2 != '0) begin
          slot[cnt[1:0]] = ~r2[DW-1:0] + DW'(1);
          cnt = cnt + 3'd1;
        end
      end
    end
    onext.status      = rs_end.azero;
    onext.root_count  = cnt;
    onext.root_first  = slot[0];
    onext.root_second = slot[1];
    onext.root_third  = slot[2];
    onext.root_fourth = slot[3];
    onext.overflow    = !rs_end.azero && !rs_end.dneg &&
                        (rs_end.ovf1 || (!rs_end.dzero && rs_end.ovf2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= r1_valid && r2_valid;
    end
    if (en) begin
      odata <= onext;
    end
  end

  assign roots.valid = ovalid;
  assign roots.data  = odata;

endmodule

/* src/brr_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_check
// Port-level checks on the root solver, bound to the top level.
// ----------------------------------------------------------------------------
module brr_check (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input brr_pkg::result_t out_data
);
  import brr_pkg::*;

  // out-of-range count never shows up
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.root_count <= 3'd4)
    else $error("root count above four");

  // a degenerate request carries nothing else
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      out_data.root_count == 3'd0 && !out_data.overflow &&
      out_data.root_first == '0 && out_data.root_second == '0 &&
      out_data.root_third == '0 && out_data.root_fourth == '0)
    else $error("degenerate result not clean");

  // unused slots read zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.root_count > 3'd0 || out_data.root_first == '0) &&
      (out_data.root_count > 3'd1 || out_data.root_second == '0) &&
      (out_data.root_count > 3'd2 || out_data.root_third == '0) &&
      (out_data.root_count > 3'd3 || out_data.root_fourth == '0))
    else $error("unused root slot not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind biquadratic_real_roots brr_check u_brr_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (roots.valid),
  .out_ready (roots.ready),
  .out_data  (roots.data)
);

/* test/biquadratic_real_roots_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquadratic_real_roots_test
// Self-checking bench for the biquadratic real root solver. A directed table
// of coefficient requests is followed by random requests: fully random words,
// equations built from chosen y values, zero leading or constant coefficients
// and small coefficients. Each result is checked field by field against an
// in-bench fixed-point solver, with random idling on both channels.
// ----------------------------------------------------------------------------
module biquadratic_real_roots_test;
  import brr_pkg::*;

  localparam int  RANDOM_REQUESTS = 530;
  localparam int  DRAIN_CYCLES    = 140;
  localparam int  CYCLE_LIMIT     = 400000;
  localparam logic [31:0] ONE     = 32'h0001_0000;

  typedef struct {
    coef_t   coef;
    bit      known;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brr_in_if  coefs_if();
  brr_out_if roots_if();

  biquadratic_real_roots dut (
    .clk   (clk),
    .rst   (rst),
    .coefs (coefs_if),
    .roots (roots_if)
  );

  always #4 clk = ~clk;

  result_t pending_roots[$];
  row_t    plan[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;
  bit      done = 1'b0;

  function automatic logic [33:0] floor_sqrt(input logic [65:0] v);
    logic [33:0] r;
    logic [33:0] t;
    logic [67:0] sq;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      t  = r | (34'd1 << i);
      sq = {34'd0, t} * {34'd0, t};
      if (sq <= {2'b00, v}) r = t;
    end
    return r;
  endfunction

  function automatic longint floor_quot(input longint num, input longint den,
                                        inout bit ovf);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
    if (q > 64'sh7FFF_FFFF) begin
      ovf = 1'b1;
      q   = 64'sh7FFF_FFFF;
    end else if (q < -64'sh8000_0000) begin
      ovf = 1'b1;
      q   = -64'sh8000_0000;
    end
    return q;
  endfunction

  function automatic result_t solve_biquad(input coef_t x);
    result_t            res;
    logic signed [67:0] aw, bw, cw, disc;
    longint             s, nb, ys[2];
    int                 ny, n;
    bit                 ovf;
    logic signed [31:0] rts[4];
    logic [33:0]        rt;
    res = '0;
    ovf = 1'b0;
    ny  = 0;
    n   = 0;
    for (int k = 0; k < 4; k++) rts[k] = '0;
    if (x.coef_quartic == 0) begin
      res.status = 1'b1;
      return res;
    end
    aw   = x.coef_quartic;
    bw   = x.coef_square;
    cw   = x.coef_const;
    disc = bw * bw - 4 * aw * cw;
    nb   = -longint'(x.coef_square);
    if (disc == 0) begin
      ys[0] = floor_quot(nb * 32768, longint'(x.coef_quartic), ovf);
      ny    = 1;
    end else if (disc > 0) begin
      s     = longint'(floor_sqrt(disc[65:0]));
      ys[0] = floor_quot((nb + s) * 32768, longint'(x.coef_quartic), ovf);
      ys[1] = floor_quot((nb - s) * 32768, longint'(x.coef_quartic), ovf);
      ny    = 2;
    end
    for (int k = 0; k < ny; k++) begin
      if (ys[k] >= 0) begin
        rt = floor_sqrt(66'(ys[k]) << 16);
        if (n < 4) begin
          rts[n] = rt[31:0];
          n++;
        end
        if (ys[k] > 0 && n < 4) begin
          rts[n] = -rt[31:0];
          n++;
        end
      end
    end
    res.root_count  = 3'(n);
    res.root_first  = rts[0];
    res.root_second = rts[1];
    res.root_third  = rts[2];
    res.root_fourth = rts[3];
    res.overflow    = ovf;
    return res;
  endfunction

  function automatic void add_row(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c);
    row_t r;
    r.coef  = '{coef_quartic: a, coef_square: b, coef_const: c};
    r.known = 1'b0;
    r.res   = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_known(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input result_t res);
    row_t r;
    r.coef  = '{coef_quartic: a, coef_square: b, coef_const: c};
    r.known = 1'b1;
    r.res   = res;
    plan.push_back(r);
  endfunction

  function automatic coef_t random_coefs();
    coef_t       x;
    int          mode;
    int          y1, y2;
    logic [31:0] a;
    mode = $urandom_range(0, 9);
    x    = {$urandom(), $urandom(), $urandom()};
    if (mode < 5) begin
      // equation in y built from two chosen integer values
      y1 = $urandom_range(0, 40) - 20;
      y2 = $urandom_range(0, 40) - 20;
      a  = ($urandom_range(1, 1 << 18)) * ($urandom_range(0, 1) ? 1 : -1);
      x.coef_quartic = a;
      x.coef_square  = -$signed(a) * (y1 + y2);
      x.coef_const   = $signed(a) * y1 * y2;
    end else if (mode == 5) begin
      x.coef_quartic = '0;
    end else if (mode == 6) begin
      x.coef_const = '0;
    end else if (mode == 7) begin
      x.coef_quartic = $signed($urandom_range(0, 1023)) - 512;
      x.coef_square  = $signed($urandom_range(0, 65535)) - 32768;
      x.coef_const   = $signed($urandom_range(0, 65535)) - 32768;
    end
    return x;
  endfunction

  task automatic send_request(input coef_t x, input bit known,
                              input result_t res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      coefs_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    coefs_if.valid <= 1'b1;
    coefs_if.data  <= x;
    @(posedge clk);
    while (!coefs_if.ready) @(posedge clk);
    pending_roots.push_back(known ? res : solve_biquad(x));
  endtask

  // result sink: check accepted results, then choose the next ready
  int stall_left = 0;
  always @(posedge clk) begin
    result_t e;
    result_t g;
    if (!rst && roots_if.valid && roots_if.ready) begin
      g = roots_if.data;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", g);
      end else begin
        e = pending_roots.pop_front();
        if (g.status !== e.status || g.root_count !== e.root_count ||
            g.root_first !== e.root_first || g.root_second !== e.root_second ||
            g.root_third !== e.root_third || g.root_fourth !== e.root_fourth ||
            g.overflow !== e.overflow) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, g);
        end
      end
    end
    if (rst) begin
      roots_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      roots_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      roots_if.ready <= 1'b0;
    end else begin
      roots_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT && !done) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    result_t none;
    result_t degenerate;
    coef_t   x;
    none       = '0;
    degenerate = '0;
    degenerate.status = 1'b1;
    coefs_if.valid = 1'b0;
    coefs_if.data  = '0;

    add_known(32'h0, ONE, ONE, degenerate);
    add_known(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, degenerate);
    add_known(ONE, 32'h0, ONE, none);                    // negative discriminant
    add_row(ONE, 32'h0, 32'h0);                          // y exactly zero
    add_row(ONE, -(2 * ONE), ONE);                       // zero discriminant
    add_row(ONE, -(5 * ONE), 4 * ONE);                   // four roots
    add_row(ONE, -(1 * ONE), 32'h0);                     // y zero and y positive
    add_row(ONE, 32'h0, -ONE);                           // one positive, one negative
    add_row(-ONE, 5 * ONE, -(4 * ONE));
    add_row(ONE, 2 * ONE, ONE);                          // double negative y
    add_row(ONE, ONE, ONE);
    add_row(32'h1, 32'h8000_0001, 32'h0);                // quotient saturates high
    add_row(32'h1, 32'h7FFF_FFFF, 32'h0);
    add_row(32'h1, 32'h0, 32'h8000_0000);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_row(32'h1, 32'h1, 32'h1);
    add_row(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    add_row(32'h1, 32'h0, 32'h8000_0000);
    add_row(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_request(plan[i].coef, plan[i].known, plan[i].res);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) begin
        coefs_if.valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
      end
      if (i == RANDOM_REQUESTS - 100) quiet = 1'b1;
      x = random_coefs();
      send_request(x, 1'b0, none);
    end
    coefs_if.valid <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    done = 1'b1;
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
